>>> rtl/chaos_game_histogram_unit_defines.svh
// Assertion macros shared by the chaos game histogram RTL.
`ifndef CHAOS_GAME_HISTOGRAM_UNIT_DEFINES_SVH
`define CHAOS_GAME_HISTOGRAM_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off during reset
`define CGH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset
`define CGH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/cgh_pkg.sv
// Package: types, codes and the symbol-to-corner map of the chaos game histogram.
`timescale 1ns / 1ps
`default_nettype none

package cgh_pkg;

  // Command codes
  localparam logic [1:0] CMD_STEP    = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  // Register word index
  localparam logic REG_STEP_FRAC = 1'b0;

  // Jump ratio in Q1.16
  localparam logic [16:0] RATIO_ONE   = 17'h10000;
  localparam logic [16:0] RATIO_RESET = 17'h08000;

  // Corner codes
  localparam logic [1:0] CORNER_A = 2'd0;  // bottom-left
  localparam logic [1:0] CORNER_C = 2'd1;  // top-left
  localparam logic [1:0] CORNER_G = 2'd2;  // top-right
  localparam logic [1:0] CORNER_T = 2'd3;  // bottom-right

  // Nucleotide byte codes
  localparam logic [7:0] NUC_A_UP = 8'd65;
  localparam logic [7:0] NUC_C_UP = 8'd67;
  localparam logic [7:0] NUC_G_UP = 8'd71;
  localparam logic [7:0] NUC_T_UP = 8'd84;
  localparam logic [7:0] NUC_A_LO = 8'd97;
  localparam logic [7:0] NUC_C_LO = 8'd99;
  localparam logic [7:0] NUC_G_LO = 8'd103;
  localparam logic [7:0] NUC_T_LO = 8'd116;

  // Input transaction
  typedef struct packed {
    logic [1:0] command;
    logic [7:0] symbol;
    logic [7:0] read_row;
    logic [7:0] read_col;
  } cgh_in_t;

  // Result transaction
  typedef struct packed {
    logic [7:0]  cell_row;
    logic [7:0]  cell_col;
    logic [31:0] cell_count;
    logic [24:0] point_x;
    logic [24:0] point_y;
  } cgh_out_t;

  // Point datapath controls
  typedef struct packed {
    logic mul;       // latch corner and distance products
    logic add;       // apply the jump
    logic bin;       // latch bin products
    logic recentre;  // point back to the centre
  } cgh_point_ctl_t;

  // Count store controls
  typedef struct packed {
    logic rd;     // read entry, keep its address
    logic inc;    // write back saturating increment
    logic clear;  // start clearing sweep
  } cgh_store_ctl_t;

  // Corner of a sequence byte; other bytes take their rank among
  // the non-nucleotide bytes, modulo 4.
  function automatic logic [1:0] corner_of(input logic [7:0] b);
    logic [3:0] below;
    logic [1:0] k;
    below = 4'(b > NUC_A_UP) + 4'(b > NUC_C_UP) + 4'(b > NUC_G_UP) + 4'(b > NUC_T_UP)
          + 4'(b > NUC_A_LO) + 4'(b > NUC_C_LO) + 4'(b > NUC_G_LO) + 4'(b > NUC_T_LO);
    case (b)
      NUC_A_UP, NUC_A_LO: k = CORNER_A;
      NUC_C_UP, NUC_C_LO: k = CORNER_C;
      NUC_G_UP, NUC_G_LO: k = CORNER_G;
      NUC_T_UP, NUC_T_LO: k = CORNER_T;
      default:            k = b[1:0] - below[1:0];
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

>>> rtl/cgh_point.sv
// Point datapath: jump toward a corner and binning into the grid.
`timescale 1ns / 1ps
`default_nettype none

module cgh_point
  import cgh_pkg::*;
#(
  parameter int unsigned POS_BITS       = 24,
  parameter int unsigned CELLS_PER_SIDE = 256,
  parameter int unsigned IDX_BITS       = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cgh_point_ctl_t        ctl_i,
  input  wire logic [7:0]            symbol_i,
  input  wire logic [16:0]           ratio_i,
  output logic      [POS_BITS:0]     point_x_o,
  output logic      [POS_BITS:0]     point_y_o,
  output logic      [IDX_BITS-1:0]   row_o,
  output logic      [IDX_BITS-1:0]   col_o
);

  `include "chaos_game_histogram_unit_defines.svh"

  localparam int unsigned PW  = POS_BITS + 1;
  localparam int unsigned PRW = PW + 17;
  localparam int unsigned BPW = PW + IDX_BITS + 1;

  localparam logic [PW-1:0]       ONE     = {1'b1, {POS_BITS{1'b0}}};
  localparam logic [PW-1:0]       HALF    = {2'b01, {(POS_BITS - 1){1'b0}}};
  localparam logic [IDX_BITS:0]   CELLS   = (IDX_BITS + 1)'(CELLS_PER_SIDE);
  localparam logic [IDX_BITS-1:0] MAX_IDX = IDX_BITS'(CELLS_PER_SIDE - 1);
  localparam logic [PRW:0]        ROUND   = (PRW + 1)'(16'hFFFF);

  logic [PW-1:0]  px_q, px_d, py_q, py_d;
  logic           hix_q, hiy_q;
  logic [PRW-1:0] prodx_q, prody_q;
  logic [BPW-1:0] binx_q, biny_q;

  logic [1:0]     corner;
  logic           hix, hiy;
  logic [PW-1:0]  distx, disty;
  logic [PRW:0]   roundx, roundy;
  logic [IDX_BITS:0] bx, by;

  // Corner and distance to it
  assign corner = corner_of(symbol_i);
  assign hix    = corner[1];
  assign hiy    = ~(corner[1] ^ corner[0]);
  assign distx  = hix ? ONE - px_q : px_q;
  assign disty  = hiy ? ONE - py_q : py_q;

  // Products, direction kept alongside
  always_ff @(posedge clk_i) begin
    if (ctl_i.mul) begin
      prodx_q <= PRW'(distx) * PRW'(ratio_i);
      prody_q <= PRW'(disty) * PRW'(ratio_i);
      hix_q   <= hix;
      hiy_q   <= hiy;
    end
  end

  // Jump: floor toward the high corner, ceiling toward zero
  assign roundx = {1'b0, prodx_q} + ROUND;
  assign roundy = {1'b0, prody_q} + ROUND;

  always_comb begin
    px_d = hix_q ? px_q + PW'(prodx_q >> 16) : px_q - PW'(roundx >> 16);
    py_d = hiy_q ? py_q + PW'(prody_q >> 16) : py_q - PW'(roundy >> 16);
  end

  // Point registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= HALF;
      py_q <= HALF;
    end else if (ctl_i.recentre) begin
      px_q <= HALF;
      py_q <= HALF;
    end else if (ctl_i.add) begin
      px_q <= px_d;
      py_q <= py_d;
    end
  end

  // Bin products
  always_ff @(posedge clk_i) begin
    if (ctl_i.bin) begin
      binx_q <= BPW'(px_q) * BPW'(CELLS);
      biny_q <= BPW'(py_q) * BPW'(CELLS);
    end
  end

  // Bin index, clamped to the last cell
  assign bx    = (IDX_BITS + 1)'(binx_q >> POS_BITS);
  assign by    = (IDX_BITS + 1)'(biny_q >> POS_BITS);
  assign col_o = (bx >= CELLS) ? MAX_IDX : IDX_BITS'(bx);
  assign row_o = (by >= CELLS) ? MAX_IDX : IDX_BITS'(by);

  assign point_x_o = px_q;
  assign point_y_o = py_q;

  `CGH_ASSERT_NOW(a_point_in_square, 1'b1, (px_q <= ONE) && (py_q <= ONE), "point left the square")
  `CGH_ASSERT_NOW(a_ctl_exclusive, ctl_i.add, !ctl_i.mul && !ctl_i.recentre, "point ctl overlap")

endmodule

`default_nettype wire

>>> rtl/cgh_store.sv
// Count store: grid counters in a synchronous RAM, read-modify-write and clearing sweep.
`timescale 1ns / 1ps
`default_nettype none

module cgh_store
  import cgh_pkg::*;
#(
  parameter int unsigned ADDR_BITS  = 16,
  parameter int unsigned COUNT_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cgh_store_ctl_t        ctl_i,
  input  wire logic [ADDR_BITS-1:0]  addr_i,
  output logic      [COUNT_BITS-1:0] rd_data_o,
  output logic      [COUNT_BITS-1:0] new_count_o,
  output logic                       clearing_o
);

  `include "chaos_game_histogram_unit_defines.svh"

  localparam int unsigned DEPTH = 2 ** ADDR_BITS;

  logic [COUNT_BITS-1:0] mem [DEPTH];
  logic [COUNT_BITS-1:0] rd_data_q;
  logic [ADDR_BITS-1:0]  addr_q;
  logic [ADDR_BITS-1:0]  clr_addr_q;
  logic                  clr_run_q;

  logic                  wr_en;
  logic [ADDR_BITS-1:0]  wr_addr;
  logic [COUNT_BITS-1:0] wr_data;
  logic [COUNT_BITS-1:0] inc_count;

  // Saturating increment of the entry just read
  assign inc_count = (&rd_data_q) ? rd_data_q : rd_data_q + COUNT_BITS'(1);

  // Single write port: sweep or write-back
  assign wr_en   = clr_run_q | ctl_i.inc;
  assign wr_addr = clr_run_q ? clr_addr_q : addr_q;
  assign wr_data = clr_run_q ? '0 : inc_count;

  // RAM
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl_i.rd) begin
      rd_data_q <= mem[addr_i];
    end
  end

  // Address held for the write-back
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd) begin
      addr_q <= addr_i;
    end
  end

  // Clearing sweep, one entry a cycle, runs from reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_run_q  <= 1'b1;
      clr_addr_q <= '0;
    end else if (ctl_i.clear) begin
      clr_run_q  <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_run_q) begin
      if (&clr_addr_q) begin
        clr_run_q <= 1'b0;
      end
      clr_addr_q <= clr_addr_q + ADDR_BITS'(1);
    end
  end

  assign rd_data_o   = rd_data_q;
  assign new_count_o = inc_count;
  assign clearing_o  = clr_run_q;

  `CGH_ASSERT_NOW(a_no_rmw_in_sweep, ctl_i.inc || ctl_i.rd, !clr_run_q, "access during clear")
  `CGH_ASSERT_NOW(a_inc_after_read, ctl_i.inc, $past(ctl_i.rd), "write-back without read")

endmodule

`default_nettype wire

>>> rtl/chaos_game_histogram_unit.sv
// Symbol step: the sequencer runs MUL, ADD, BIN, RD and WB, then registers the result strobe;
// busy holds off the next command until it is idle. Cell read: RD (registered RAM read), WB.
// Unused command: WB only. Restart: clearing sweep of all 2**(2*clog2(CELLS_PER_SIDE)) RAM
// entries, one entry a cycle (65536 at 256 cells a side), then a registered strobe once it ends.
// Reset: point at the centre, ratio one half, then the same sweep with busy high.
// Results are a one-cycle strobe; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module chaos_game_histogram_unit
  import cgh_pkg::*;
#(
  parameter int unsigned CELLS_PER_SIDE = 256,
  parameter int unsigned POS_BITS       = 24,
  parameter int unsigned COUNT_BITS     = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // command channel
  input  wire logic        start,
  output logic             busy,
  input  wire cgh_in_t     item_i,
  // result channel
  output logic             result_valid_o,
  output cgh_out_t         result_o,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  `include "chaos_game_histogram_unit_defines.svh"

  localparam int unsigned IDX_BITS  = $clog2(CELLS_PER_SIDE);
  localparam int unsigned ADDR_BITS = 2 * IDX_BITS;
  localparam int unsigned PW        = POS_BITS + 1;

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_BIN  = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_WB   = 3'd5;
  localparam logic [2:0] S_CLR  = 3'd6;

  logic [2:0]   state_q, state_d;
  cgh_in_t      in_q;
  logic [16:0]  ratio_q;
  logic [16:0]  ratio_eff;
  logic         valid_q, valid_d;
  cgh_out_t     out_q, out_d;

  logic         accept;
  logic         cfg_wr;
  logic         clearing;
  logic         read_in_range;
  logic         is_step;
  logic         is_read;

  cgh_point_ctl_t           pctl;
  cgh_store_ctl_t           sctl;
  logic [PW-1:0]            point_x, point_y;
  logic [IDX_BITS-1:0]      row, col;
  logic [ADDR_BITS-1:0]     addr;
  logic [COUNT_BITS-1:0]    rd_data, new_count;

  assign accept  = start & ~busy;
  assign busy    = (state_q != S_IDLE) | clearing;
  assign is_step = (in_q.command == CMD_STEP);
  assign is_read = (in_q.command == CMD_READ);

  // APB register file
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_STEP_FRAC);
  assign prdata = (paddr[2] == REG_STEP_FRAC) ? 32'(ratio_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q <= RATIO_RESET;
    end else if (cfg_wr) begin
      ratio_q <= pwdata[16:0];
    end
  end

  // Ratios above one act as one
  assign ratio_eff = (ratio_q > RATIO_ONE) ? RATIO_ONE : ratio_q;

  // Command held for the whole transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= item_i;
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (item_i.command)
            CMD_STEP:    state_d = S_MUL;
            CMD_READ:    state_d = S_RD;
            CMD_RESTART: state_d = S_CLR;
            default:     state_d = S_WB;
          endcase
        end
      end
      S_MUL:   state_d = S_ADD;
      S_ADD:   state_d = S_BIN;
      S_BIN:   state_d = S_RD;
      S_RD:    state_d = S_WB;
      S_WB:    state_d = S_IDLE;
      S_CLR: begin
        if (!clearing) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath and store controls
  always_comb begin
    pctl          = '0;
    pctl.mul      = (state_q == S_MUL);
    pctl.add      = (state_q == S_ADD);
    pctl.bin      = (state_q == S_BIN);
    pctl.recentre = accept & (item_i.command == CMD_RESTART);
    sctl          = '0;
    sctl.rd       = (state_q == S_RD);
    sctl.inc      = (state_q == S_WB) & is_step;
    sctl.clear    = pctl.recentre;
  end

  // Cell address: bin hit for a step, requested cell for a read
  assign read_in_range = ({3'b000, in_q.read_row} < 11'(CELLS_PER_SIDE))
                       & ({3'b000, in_q.read_col} < 11'(CELLS_PER_SIDE));
  assign addr = is_step ? {row, col}
                        : {IDX_BITS'(in_q.read_row), IDX_BITS'(in_q.read_col)};

  cgh_point #(
    .POS_BITS       (POS_BITS),
    .CELLS_PER_SIDE (CELLS_PER_SIDE),
    .IDX_BITS       (IDX_BITS)
  ) u_point (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (pctl),
    .symbol_i  (in_q.symbol),
    .ratio_i   (ratio_eff),
    .point_x_o (point_x),
    .point_y_o (point_y),
    .row_o     (row),
    .col_o     (col)
  );

  cgh_store #(
    .ADDR_BITS  (ADDR_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (sctl),
    .addr_i      (addr),
    .rd_data_o   (rd_data),
    .new_count_o (new_count),
    .clearing_o  (clearing)
  );

  // Result assembly
  always_comb begin
    out_d            = out_q;
    valid_d          = 1'b0;
    if ((state_q == S_WB) || ((state_q == S_CLR) && !clearing)) begin
      valid_d          = 1'b1;
      out_d.cell_row   = 8'd0;
      out_d.cell_col   = 8'd0;
      out_d.cell_count = 32'd0;
      out_d.point_x    = 25'(point_x);
      out_d.point_y    = 25'(point_y);
      if (state_q == S_WB) begin
        if (is_step) begin
          out_d.cell_row   = 8'(row);
          out_d.cell_col   = 8'(col);
          out_d.cell_count = 32'(new_count);
        end else if (is_read) begin
          out_d.cell_row   = in_q.read_row;
          out_d.cell_col   = in_q.read_col;
          out_d.cell_count = read_in_range ? 32'(rd_data) : 32'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign result_valid_o = valid_q;
  assign result_o       = out_q;

  `CGH_ASSERT_NEXT(a_accept_goes_busy, accept, busy, "accepted transaction did not raise busy")
  `CGH_ASSERT_NOW(a_result_from_work, result_valid_o, $past(state_q != S_IDLE), "stray result")

endmodule

`default_nettype wire
